@@ rtl/lde_pkg.sv @@
// lde_pkg: register indexes and fixed widths of the link delay window estimator
// no dependencies
`timescale 1ns / 1ps

package lde_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int LIMIT_WIDTH     = 10;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WINDOW_LIMIT   = 2'd0,
      CSR_DEFAULT_DELAY  = 2'd1,
      CSR_DEFAULT_SPREAD = 2'd2
   } csr_index_type;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 10'd500;

endpackage

@@ rtl/lde_ram.sv @@
// lde_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lde_div.sv @@
// lde_div: iterative unsigned divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module lde_div #(
   parameter int NUM_WIDTH = 80,
   parameter int DEN_WIDTH = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] dividend,
   input  logic [DEN_WIDTH-1:0] divisor,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] quotient
);

   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] quo_ff;
   logic [DEN_WIDTH-1:0] rem_ff;
   logic [DEN_WIDTH-1:0] den_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [DEN_WIDTH:0]   trial;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[NUM_WIDTH-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_WIDTH'(NUM_WIDTH);
            quo_ff <= dividend;
            rem_ff <= '0;
            den_ff <= divisor;
         end else if (run_ff) begin
            quo_ff <= {quo_ff[NUM_WIDTH-2:0], ge};
            rem_ff <= ge ? DEN_WIDTH'(trial - {1'b0, den_ff}) : trial[DEN_WIDTH-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_WIDTH'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/link_delay_window_estimator_unit.sv @@
// link_delay_window_estimator_unit: top level, window ring in ram, two walks, shared divider
// depends on lde_pkg, lde_ram, lde_div
`timescale 1ns / 1ps

// An item is accepted when start is high and busy is low; busy then stays high until the
// result strobe rsp_valid, which lasts one cycle and cannot be held off. Busy falls as the
// strobe rises, so the next transfer can be taken in the cycle of the strobe. The time of an
// item goes into two walks over the ring, one record per cycle through the ram read port, and
// three divisions in a one-bit-per-cycle divider. A zero limit skips both and strobes the
// result from ST_DONE, the state that follows the transfer.
// Records are read only after they are written, so no clearing pass follows reset.
module link_delay_window_estimator_unit
   import lde_pkg::*;
#(
   parameter int WINDOW_DEPTH = 512,
   parameter int TIME_WIDTH   = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [TIME_WIDTH-2:0]                 req_remote_send_time,
   input  logic [TIME_WIDTH-2:0]                 req_remote_arrival_time,
   input  logic [TIME_WIDTH-2:0]                 req_local_send_time,
   input  logic [TIME_WIDTH-2:0]                 req_local_arrival_time,
   output logic                                  rsp_valid,
   output logic [TIME_WIDTH-2:0]                 rsp_delay_estimate,
   output logic [TIME_WIDTH-2:0]                 rsp_delay_spread,
   output logic signed [TIME_WIDTH-1:0]          rsp_clock_offset,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0]     rsp_record_count,
   output logic                                  rsp_used_defaults,
   input  logic                                  csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]            csr_index,
   input  logic [TIME_WIDTH-2:0]                 csr_wdata
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int FW = TIME_WIDTH - 1;
   localparam int DW = FW + CW;
   localparam int OW = TIME_WIDTH + 1 + CW;
   localparam int MW = FW + TIME_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WALK1, ST_DIV1, ST_WALK2, ST_DIV2, ST_DIV3, ST_DONE
   } state_type;

   state_type state_ff;

   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic [FW-1:0]          def_delay_ff;
   logic [FW-1:0]          def_spread_ff;
   logic [AW-1:0]          oldest_ff;
   logic [CW-1:0]          held_ff;

   logic [CW-1:0] lim_eff;
   logic [CW:0]   held_a;
   logic [CW:0]   oldest_sum;
   logic [AW-1:0] oldest_a;
   logic [CW:0]   wr_sum;
   logic [AW-1:0] wr_addr;
   logic          accept;

   // walk control
   logic [AW-1:0] addr_ff;
   logic [CW-1:0] issue_ff;
   logic          rvalid_ff;
   logic          issuing;
   logic [MW-1:0] rd_data;
   logic [FW-1:0] rd_delay;
   logic signed [TIME_WIDTH-1:0] rd_diff;

   logic [DW-1:0]        sum_delay_ff;
   logic [DW-1:0]        sum_spread_ff;
   logic signed [OW-1:0] sum_offset_ff;
   logic [FW-1:0]        d_est_ff;
   logic [FW-1:0]        spread_q_ff;
   logic [FW-1:0]        gap;
   logic [OW-1:0]        off_mag;

   logic          div_start;
   logic [OW-1:0] div_num;
   logic          div_done;
   logic [OW-1:0] div_q;
   logic          q_big;

   assign accept = start && !busy;
   assign busy   = state_ff != ST_IDLE;

   always_comb begin
      lim_eff = (32'(limit_ff) > 32'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH) : CW'(limit_ff);
      if (held_ff >= lim_eff) begin
         held_a     = {1'b0, lim_eff} - 1'b1;
         oldest_sum = (CW+1)'(oldest_ff) + ({1'b0, held_ff} - held_a);
      end else begin
         held_a     = {1'b0, held_ff};
         oldest_sum = (CW+1)'(oldest_ff);
      end
      oldest_a = (oldest_sum >= (CW+1)'(WINDOW_DEPTH)) ?
                 AW'(oldest_sum - (CW+1)'(WINDOW_DEPTH)) : AW'(oldest_sum);
      wr_sum   = (CW+1)'(oldest_a) + held_a;
      wr_addr  = (wr_sum >= (CW+1)'(WINDOW_DEPTH)) ?
                 AW'(wr_sum - (CW+1)'(WINDOW_DEPTH)) : AW'(wr_sum);
   end

   // stored record: absolute link delay and local send minus local arrival
   logic [FW-1:0]         in_delay;
   logic [TIME_WIDTH-1:0] in_diff;
   assign in_delay = (req_remote_arrival_time >= req_remote_send_time) ?
                     req_remote_arrival_time - req_remote_send_time :
                     req_remote_send_time - req_remote_arrival_time;
   assign in_diff  = {1'b0, req_local_send_time} - {1'b0, req_local_arrival_time};

   assign issuing  = (state_ff == ST_WALK1 || state_ff == ST_WALK2) && issue_ff != held_ff;

   lde_ram #(.WIDTH(MW), .DEPTH(WINDOW_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (accept && lim_eff != '0),
      .wr_addr (wr_addr),
      .wr_data ({in_delay, in_diff}),
      .rd_en   (issuing),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rd_delay = rd_data[MW-1:TIME_WIDTH];
   assign rd_diff  = rd_data[TIME_WIDTH-1:0];
   assign gap      = (rd_delay >= d_est_ff) ? rd_delay - d_est_ff : d_est_ff - rd_delay;
   assign off_mag  = sum_offset_ff[OW-1] ? OW'(-sum_offset_ff) : OW'(sum_offset_ff);

   always_comb begin
      div_start = 1'b0;
      div_num   = OW'(sum_delay_ff);
      if (state_ff == ST_WALK1 && !issuing && !rvalid_ff) begin
         div_start = 1'b1;
      end else if (state_ff == ST_WALK2 && !issuing && !rvalid_ff) begin
         div_start = 1'b1;
         div_num   = OW'(sum_spread_ff);
      end else if (state_ff == ST_DIV2 && div_done) begin
         div_start = 1'b1;
         div_num   = off_mag;
      end
   end

   lde_div #(.NUM_WIDTH(OW), .DEN_WIDTH(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (held_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign q_big = div_q[OW-1:FW] != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= LIMIT_RESET;
         def_delay_ff  <= '0;
         def_spread_ff <= '0;
         oldest_ff     <= '0;
         held_ff       <= '0;
         rvalid_ff     <= 1'b0;
         rsp_valid     <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         rvalid_ff <= issuing;
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_LIMIT:   limit_ff      <= csr_wdata[LIMIT_WIDTH-1:0];
               CSR_DEFAULT_DELAY:  def_delay_ff  <= csr_wdata;
               CSR_DEFAULT_SPREAD: def_spread_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (issuing) begin
            issue_ff <= issue_ff + 1'b1;
            addr_ff  <= (addr_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : addr_ff + 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  issue_ff      <= '0;
                  sum_delay_ff  <= '0;
                  sum_offset_ff <= '0;
                  sum_spread_ff <= '0;
                  if (lim_eff == '0) begin
                     oldest_ff <= '0;
                     held_ff   <= '0;
                     state_ff  <= ST_DONE;
                  end else begin
                     oldest_ff <= oldest_a;
                     addr_ff   <= oldest_a;
                     held_ff   <= CW'(held_a + 1'b1);
                     state_ff  <= ST_WALK1;
                  end
               end
            end
            ST_WALK1: begin
               if (rvalid_ff) begin
                  sum_delay_ff <= sum_delay_ff + DW'(rd_delay);
               end
               if (div_start) begin
                  state_ff <= ST_DIV1;
               end
            end
            ST_DIV1: begin
               if (div_done) begin
                  d_est_ff <= (held_ff <= CW'(1)) ? def_delay_ff : div_q[FW-1:0];
                  issue_ff <= '0;
                  addr_ff  <= oldest_ff;
                  state_ff <= ST_WALK2;
               end
            end
            ST_WALK2: begin
               if (rvalid_ff) begin
                  sum_spread_ff <= sum_spread_ff + DW'(gap);
                  sum_offset_ff <= sum_offset_ff + OW'(rd_diff) + OW'({1'b0, d_est_ff});
               end
               if (div_start) begin
                  state_ff <= ST_DIV2;
               end
            end
            ST_DIV2: begin
               if (div_done) begin
                  spread_q_ff <= div_q[FW-1:0];
                  state_ff    <= ST_DIV3;
               end
            end
            ST_DIV3: begin
               if (div_done) begin
                  // saturate the mean offset to the signed range
                  if (!sum_offset_ff[OW-1]) begin
                     rsp_clock_offset <= q_big ? {1'b0, {FW{1'b1}}} : {1'b0, div_q[FW-1:0]};
                  end else begin
                     rsp_clock_offset <= q_big ? {1'b1, {FW{1'b0}}} :
                                         -{1'b0, div_q[FW-1:0]};
                  end
                  rsp_delay_estimate <= d_est_ff;
                  rsp_delay_spread   <= (held_ff <= CW'(1)) ? def_spread_ff : spread_q_ff;
                  rsp_record_count   <= held_ff;
                  rsp_used_defaults  <= held_ff <= CW'(1);
                  rsp_valid          <= 1'b1;
                  state_ff           <= ST_IDLE;
               end
            end
            ST_DONE: begin
               // empty window
               rsp_clock_offset   <= '0;
               rsp_delay_estimate <= def_delay_ff;
               rsp_delay_spread   <= def_spread_ff;
               rsp_record_count   <= '0;
               rsp_used_defaults  <= 1'b1;
               rsp_valid          <= 1'b1;
               state_ff           <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/lde_checker.sv @@
// lde_checker: port level assertions for the link delay window estimator
// bound to link_delay_window_estimator_unit, no package dependency
`timescale 1ns / 1ps

module lde_checker #(
   parameter int WINDOW_DEPTH = 512,
   parameter int TIME_WIDTH   = 64
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic signed [TIME_WIDTH-1:0]      rsp_clock_offset,
   input logic [$clog2(WINDOW_DEPTH+1)-1:0] rsp_record_count,
   input logic                              rsp_used_defaults
);

   // a transfer in makes the block busy until its result
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after transfer");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_record_count) <= 32'(WINDOW_DEPTH))
      else $error("record count beyond window depth");

   a_defaults_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_defaults == (rsp_record_count <= 1))
      else $error("defaults flag disagrees with record count");

   a_empty_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_count == 0 |-> rsp_clock_offset == 0)
      else $error("empty window with nonzero offset");

endmodule

bind link_delay_window_estimator_unit lde_checker #(
   .WINDOW_DEPTH(WINDOW_DEPTH),
   .TIME_WIDTH(TIME_WIDTH)
) u_lde_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_clock_offset  (rsp_clock_offset),
   .rsp_record_count  (rsp_record_count),
   .rsp_used_defaults (rsp_used_defaults)
);

@@ tb/tb.sv @@
// tb: self-checking testbench for link_delay_window_estimator_unit
// depends on lde_pkg and the rtl top level; a scoreboard class predicts window means
`timescale 1ns / 1ps

module tb;
   import lde_pkg::*;

   localparam int DEPTH     = 512;
   localparam int TW        = 64;
   localparam int CW        = $clog2(DEPTH + 1);
   localparam int IDLE_MAX  = 6000;
   localparam bit [62:0] T_MAX = {63{1'b1}};

   typedef struct {
      bit [62:0] remote_send;
      bit [62:0] remote_arrival;
      bit [62:0] local_send;
      bit [62:0] local_arrival;
   } timing_record_type;

   typedef struct {
      bit [62:0]        delay;
      bit [62:0]        spread;
      bit signed [63:0] offset;
      bit [CW-1:0]      count;
      bit               defaults;
   } estimate_type;

   class window_scoreboard;
      timing_record_type window_q[$];
      estimate_type      expected_q[$];
      bit [9:0]          limit;
      bit [62:0]         dflt_delay;
      bit [62:0]         dflt_spread;
      int                errors;

      function void set_reg(csr_index_type idx, bit [62:0] value);
         case (idx)
            CSR_WINDOW_LIMIT:   limit = value[9:0];
            CSR_DEFAULT_DELAY:  dflt_delay = value;
            CSR_DEFAULT_SPREAD: dflt_spread = value;
            default: ;
         endcase
      endfunction

      function bit [62:0] abs_delay(timing_record_type r);
         return (r.remote_arrival >= r.remote_send) ? r.remote_arrival - r.remote_send
                                                    : r.remote_send - r.remote_arrival;
      endfunction

      function void note_input(timing_record_type r);
         int           lim;
         int           n;
         bit [127:0]   acc;
         bit [127:0]   mag;
         bit [127:0]   q;
         bit [62:0]    gap;
         bit           neg;
         estimate_type e;
         lim = (limit > DEPTH) ? DEPTH : int'(limit);
         if (lim == 0) begin
            window_q.delete();
         end else begin
            while (window_q.size() >= lim) void'(window_q.pop_front());
            window_q.insert(window_q.size(), r);
         end
         n = window_q.size();
         if (n <= 1) begin
            e.delay = dflt_delay;
            e.spread = dflt_spread;
            e.defaults = 1'b1;
         end else begin
            acc = '0;
            foreach (window_q[k]) acc += abs_delay(window_q[k]);
            q = acc / n;
            e.delay = q[62:0];
            acc = '0;
            foreach (window_q[k]) begin
               gap = abs_delay(window_q[k]);
               acc += (gap >= e.delay) ? gap - e.delay : e.delay - gap;
            end
            q = acc / n;
            e.spread = q[62:0];
            e.defaults = 1'b0;
         end
         if (n == 0) begin
            e.offset = '0;
         end else begin
            // exact signed sum, then truncating division with saturation
            acc = '0;
            foreach (window_q[k])
               acc += {65'b0, window_q[k].local_send} + {65'b0, e.delay}
                      - {65'b0, window_q[k].local_arrival};
            neg = acc[127];
            mag = neg ? -acc : acc;
            q = mag / n;
            if (!neg) e.offset = (q > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                                : q[63:0];
            else e.offset = (q >= 128'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                                            : -q[63:0];
         end
         e.count = CW'(n);
         expected_q.insert(expected_q.size(), e);
      endfunction

      function void check(estimate_type got);
         estimate_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, delay %0d", $time, got.delay);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.delay !== e.delay) begin
            $display("%0t: delay_estimate exp %0d got %0d", $time, e.delay, got.delay);
            errors++;
         end
         if (got.spread !== e.spread) begin
            $display("%0t: delay_spread exp %0d got %0d", $time, e.spread, got.spread);
            errors++;
         end
         if (got.offset !== e.offset) begin
            $display("%0t: clock_offset exp %0d got %0d", $time, e.offset, got.offset);
            errors++;
         end
         if (got.count !== e.count) begin
            $display("%0t: record_count exp %0d got %0d", $time, e.count, got.count);
            errors++;
         end
         if (got.defaults !== e.defaults) begin
            $display("%0t: used_defaults exp %0d got %0d", $time, e.defaults, got.defaults);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [TW-2:0]             req_remote_send_time;
   logic [TW-2:0]             req_remote_arrival_time;
   logic [TW-2:0]             req_local_send_time;
   logic [TW-2:0]             req_local_arrival_time;
   logic                      rsp_valid;
   logic [TW-2:0]             rsp_delay_estimate;
   logic [TW-2:0]             rsp_delay_spread;
   logic signed [TW-1:0]      rsp_clock_offset;
   logic [CW-1:0]             rsp_record_count;
   logic                      rsp_used_defaults;
   logic                      csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [TW-2:0]             csr_wdata;

   window_scoreboard sb;
   int               idle_cycles;
   int               burst_left;

   link_delay_window_estimator_unit #(.WINDOW_DEPTH(DEPTH), .TIME_WIDTH(TW)) uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // results cannot be held off, so every strobe is a transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check('{rsp_delay_estimate, rsp_delay_spread, rsp_clock_offset,
                    rsp_record_count, rsp_used_defaults});
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("link_delay_window_estimator_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic bit [62:0] rand_time(int mode);
      bit [62:0] v;
      v = 63'({$urandom, $urandom});
      case (mode)
         0: return v;
         1: return 63'($urandom_range(0, 1000));
         2: return T_MAX - 63'($urandom_range(0, 1000));
         default: return {v[62:40], 40'b0} | 63'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic timing_record_type rand_record();
      timing_record_type r;
      bit [62:0]         base;
      if ($urandom_range(0, 3) == 0) begin
         r.remote_send = rand_time($urandom_range(0, 3));
         r.remote_arrival = rand_time($urandom_range(0, 3));
         r.local_send = rand_time($urandom_range(0, 3));
         r.local_arrival = rand_time($urandom_range(0, 3));
      end else begin
         // plausible record: short delay, small clock skew
         base = rand_time(0);
         r.remote_send = base;
         r.remote_arrival = base + 63'($urandom_range(0, 5000));
         if ($urandom_range(0, 7) == 0) r.remote_arrival = base - 63'($urandom_range(0, 500));
         r.local_send = base + 63'($urandom_range(0, 20000));
         r.local_arrival = r.local_send + 63'($urandom_range(0, 9000));
      end
      return r;
   endfunction

   task automatic wait_drained();
      while (sb.expected_q.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_regs(bit [9:0] lim, bit [62:0] dd, bit [62:0] ds);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_WINDOW_LIMIT;
      csr_wdata <= 63'(lim);
      sb.set_reg(CSR_WINDOW_LIMIT, 63'(lim));
      @(posedge clock);
      csr_index <= CSR_DEFAULT_DELAY;
      csr_wdata <= dd;
      sb.set_reg(CSR_DEFAULT_DELAY, dd);
      @(posedge clock);
      csr_index <= CSR_DEFAULT_SPREAD;
      csr_wdata <= ds;
      sb.set_reg(CSR_DEFAULT_SPREAD, ds);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // start stays high through a burst and drops in the step of its last transfer
   task automatic send_record(timing_record_type r);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      start <= 1'b1;
      req_remote_send_time <= r.remote_send;
      req_remote_arrival_time <= r.remote_arrival;
      req_local_send_time <= r.local_send;
      req_local_arrival_time <= r.local_arrival;
      do @(posedge clock); while (busy);
      sb.note_input(r);
      if (burst_left == 0) start <= 1'b0;
   endtask

   // cut a running burst short; start is already low when the burst ended
   task automatic pause_sender();
      if (burst_left != 0) start <= 1'b0;
      burst_left = 0;
   endtask

   task automatic run_phase(bit [9:0] lim, bit [62:0] dd, bit [62:0] ds, int items);
      pause_sender();
      wait_drained();
      write_regs(lim, dd, ds);
      repeat (items) send_record(rand_record());
   endtask

   task automatic send_fixed(bit [62:0] rs, bit [62:0] ra, bit [62:0] ls, bit [62:0] la);
      timing_record_type r;
      r = '{rs, ra, ls, la};
      send_record(r);
   endtask

   initial begin
      sb = new();
      sb.limit = LIMIT_RESET;
      sb.dflt_delay = '0;
      sb.dflt_spread = '0;
      sb.errors = 0;
      burst_left = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_remote_send_time <= '0;
      req_remote_arrival_time <= '0;
      req_local_send_time <= '0;
      req_local_arrival_time <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_WINDOW_LIMIT;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset registers: single record takes defaults, then extremes of the fields
      send_fixed(63'd0, 63'd0, 63'd0, 63'd0);
      send_fixed(T_MAX, T_MAX, T_MAX, T_MAX);
      send_fixed(T_MAX, 63'd0, 63'd0, T_MAX);
      send_fixed(63'd0, T_MAX, T_MAX, 63'd0);
      send_fixed(63'd100, 63'd50, 63'd1000, 63'd900);
      // single record with a large default delay saturates the offset
      run_phase(10'd1, T_MAX, T_MAX, 0);
      send_fixed(63'd5, 63'd9, T_MAX, 63'd0);
      send_fixed(63'd5, 63'd9, 63'd0, T_MAX);
      send_fixed(63'd0, 63'd0, 63'd0, 63'd0);
      // two records, mean offset beyond the signed range
      run_phase(10'd2, 63'd7, 63'd3, 0);
      send_fixed(63'd0, T_MAX, T_MAX, 63'd0);
      send_fixed(T_MAX, 63'd0, T_MAX, 63'd0);
      send_fixed(63'd0, T_MAX, T_MAX, 63'd0);
      send_fixed(63'd10, 63'd20, 63'd0, T_MAX);
      send_fixed(63'd20, 63'd10, 63'd0, T_MAX);
      // zero limit empties the window
      run_phase(10'd0, 63'd11, 63'd22, 0);
      send_fixed(63'd1, 63'd2, 63'd3, 63'd4);
      send_fixed(T_MAX, 63'd0, T_MAX, 63'd0);

      run_phase(LIMIT_RESET, 63'd0, 63'd0, 30);
      run_phase(10'd1023, T_MAX, 63'd5, 30);
      run_phase(10'd40, rand_time(0), rand_time(0), 70);
      run_phase(10'd3, rand_time(1), rand_time(0), 40);
      run_phase(10'd0, rand_time(0), rand_time(1), 15);
      run_phase(10'd1, rand_time(0), rand_time(0), 20);
      run_phase(10'd2, rand_time(2), rand_time(2), 30);
      run_phase(10'd512, rand_time(0), rand_time(0), 40);
      repeat (5)
         run_phase(10'($urandom_range(4, 60)), rand_time(0), rand_time(0), 50);

      pause_sender();
      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("link_delay_window_estimator_unit regression: pass");
      end else begin
         $display("link_delay_window_estimator_unit regression: fail");
      end
      $finish;
   end

endmodule
